[hdl/assert_macros.svh]
// Assertion helpers used by the oscillator RTL.
// All macros expect clk and rst_n in scope; checks are off while in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, sampled on the rising edge.
`define IWO_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Same-cycle implication.
`define IWO_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication failed");

`endif

[hdl/iwo_pkg.sv]
package iwo_pkg;

  // Table store
  localparam int TABLE_DEPTH  = 512;
  localparam int ADDR_W       = $clog2(TABLE_DEPTH);
  localparam int SAMPLE_W     = 16;

  // Phase format: integer table index plus fraction
  localparam int FRAC_W       = 16;
  localparam int PHASE_W      = ADDR_W + FRAC_W;

  // Configuration register widths and reset values
  localparam int LEN_W        = 10;
  localparam int SCALE_W      = 32;
  localparam int SCALE_FRAC_W = 32;
  localparam int FREQ_W       = 24;
  localparam logic [LEN_W-1:0]   RESET_TABLE_LENGTH    = LEN_W'(512);
  localparam logic [SCALE_W-1:0] RESET_INCREMENT_SCALE = SCALE_W'(268435);

  // Stream packing
  localparam int CMD_W        = 2;
  localparam int IN_FIELDS_W  = ADDR_W + SAMPLE_W + FREQ_W;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_DATA_W   = ((SAMPLE_W + 7) / 8) * 8;
  localparam int CFG_IDX_W    = 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD    = 2'd0,
    CMD_STEP    = 2'd1,
    CMD_RESTART = 2'd2
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TABLE_LENGTH    = 1'b0,
    REG_INCREMENT_SCALE = 1'b1
  } reg_idx_t;

  typedef logic [ADDR_W-1:0]   addr_t;
  typedef logic [SAMPLE_W-1:0] sample_t;

endpackage

[hdl/iwo_wave_ram.sv]
module iwo_wave_ram
  import iwo_pkg::*;
(
  input  logic    clk,
  input  logic    wr_en,
  input  addr_t   wr_addr,
  input  sample_t wr_data,
  input  logic    rd_en,
  input  addr_t   rd_addr,
  output sample_t rd_data
);

  sample_t mem [TABLE_DEPTH];
  sample_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[hdl/interpolating_wavetable_oscillator.sv]
// Wavetable oscillator with linear interpolation. Requests carry a command in
// in_tuser: load writes one signed Q1.15 entry into the 512-entry table, restart
// clears the phase, and step advances the phase by frequency * increment_scale
// (saturated below the table length, wrapped once) and returns one interpolated
// Q1.15 sample on the out channel. Load and restart give no result. A step goes
// from acceptance to the output register through one multiply, one phase update,
// then two reads through the single table read port, one interpolation multiply
// and the final add; one step is in flight at a time, so the next request is
// taken no earlier than the cycle after the result.
// The result sits in an output register, so back-pressure on out only delays
// the next step once a second result is ready. Reading a never-loaded entry
// gives an undefined sample. cfg_ready is low while a step is running.
`include "assert_macros.svh"

module interpolating_wavetable_oscillator
  import iwo_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // in
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,  // table_address, table_value, frequency, zero pad
  input  logic [CMD_W-1:0]      in_tuser,  // command
  // out
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata, // sample
  // configuration
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [SCALE_W-1:0]    cfg_data
);

  localparam int PROD_W  = FREQ_W + SCALE_W;
  localparam int INC_W   = PROD_W - (SCALE_FRAC_W - FRAC_W);
  localparam int LIMIT_W = LEN_W + FRAC_W;
  localparam int DIFF_W  = SAMPLE_W + 1;
  localparam int IPROD_W = DIFF_W + FRAC_W + 1;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_PHASE, S_RDA, S_RDB, S_MULI, S_OUT
  } state_t;

  state_t                    state_r;
  logic [LEN_W-1:0]          len_r;
  logic [SCALE_W-1:0]        scale_r;
  logic [PHASE_W-1:0]        phase_r;
  logic [FREQ_W-1:0]         freq_r;
  logic [PROD_W-1:0]         prod_r;
  sample_t                   a_r;
  logic signed [IPROD_W-1:0] iprod_r;
  logic                      out_valid_r;
  sample_t                   out_data_r;

  // input fields
  cmd_t                in_cmd;
  addr_t               in_addr;
  sample_t             in_value;
  logic [FREQ_W-1:0]   in_freq;
  logic                in_fire;

  assign in_cmd   = cmd_t'(in_tuser);
  assign in_addr  = in_tdata[ADDR_W-1:0];
  assign in_value = in_tdata[ADDR_W +: SAMPLE_W];
  assign in_freq  = in_tdata[ADDR_W+SAMPLE_W +: FREQ_W];

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = (state_r == S_IDLE);

  // clamp the length into 2 .. TABLE_DEPTH
  logic [LEN_W-1:0]   len_eff;
  logic [LIMIT_W-1:0] limit;
  logic [LIMIT_W-1:0] limit_m1;

  always_comb begin
    priority if (len_r < LEN_W'(2)) begin
      len_eff = LEN_W'(2);
    end else if (len_r > LEN_W'(TABLE_DEPTH)) begin
      len_eff = LEN_W'(TABLE_DEPTH);
    end else begin
      len_eff = len_r;
    end
  end

  assign limit    = {len_eff, {FRAC_W{1'b0}}};
  assign limit_m1 = limit - LIMIT_W'(1);

  // phase update
  logic [INC_W-1:0]   inc_full;
  logic [PHASE_W-1:0] inc_sat;
  logic [PHASE_W-1:0] phase_base;
  logic [LIMIT_W-1:0] phase_sum;
  logic [PHASE_W-1:0] phase_nxt;

  assign inc_full   = prod_r[PROD_W-1 -: INC_W];
  assign inc_sat    = (inc_full > INC_W'(limit_m1)) ? PHASE_W'(limit_m1) : PHASE_W'(inc_full);
  assign phase_base = (LIMIT_W'(phase_r) >= limit) ? '0 : phase_r;
  assign phase_sum  = LIMIT_W'(phase_base) + LIMIT_W'(inc_sat);
  assign phase_nxt  = (phase_sum >= limit) ? PHASE_W'(phase_sum - limit) : PHASE_W'(phase_sum);

  // neighbour entry, wrapping at the length in use
  addr_t            lower;
  logic [LEN_W-1:0] upper_full;
  addr_t            upper;

  assign lower      = phase_r[PHASE_W-1 -: ADDR_W];
  assign upper_full = LEN_W'(lower) + LEN_W'(1);
  assign upper      = (upper_full >= len_eff) ? '0 : upper_full[ADDR_W-1:0];

  // table
  logic    ram_rd_en;
  addr_t   ram_rd_addr;
  sample_t ram_rd_data;

  assign ram_rd_en   = (state_r == S_RDA) || (state_r == S_RDB);
  assign ram_rd_addr = (state_r == S_RDA) ? lower : upper;

  iwo_wave_ram u_ram (
    .clk     (clk),
    .wr_en   (in_fire && (in_cmd == CMD_LOAD)),
    .wr_addr (in_addr),
    .wr_data (in_value),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // interpolation: a + floor((b - a) * frac / 2^FRAC_W)
  logic signed [DIFF_W-1:0]  diff;
  logic signed [IPROD_W-1:0] iprod_nxt;
  sample_t                   sample_nxt;
  logic                      out_free;

  assign diff       = DIFF_W'($signed(ram_rd_data)) - DIFF_W'($signed(a_r));
  assign iprod_nxt  = IPROD_W'(diff) * $signed({1'b0, phase_r[FRAC_W-1:0]});
  // result always lies between a and b, so the low bits are exact
  assign sample_nxt = a_r + iprod_r[FRAC_W +: SAMPLE_W];
  assign out_free   = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_r       <= RESET_TABLE_LENGTH;
      scale_r     <= RESET_INCREMENT_SCALE;
      phase_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (reg_idx_t'(cfg_index))
          REG_TABLE_LENGTH:    len_r   <= cfg_data[LEN_W-1:0];
          REG_INCREMENT_SCALE: scale_r <= cfg_data;
          default: ;
        endcase
      end

      // in S_OUT the output register is reloaded below instead
      if (out_valid_r && out_tready && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            unique case (in_cmd)
              CMD_STEP: begin
                freq_r  <= in_freq;
                state_r <= S_MUL;
              end
              CMD_RESTART: phase_r <= '0;
              default: ;
            endcase
          end
        end
        S_MUL: begin
          prod_r  <= PROD_W'(freq_r) * PROD_W'(scale_r);
          state_r <= S_PHASE;
        end
        S_PHASE: begin
          phase_r <= phase_nxt;
          state_r <= S_RDA;
        end
        S_RDA: state_r <= S_RDB;
        S_RDB: begin
          a_r     <= ram_rd_data;
          state_r <= S_MULI;
        end
        S_MULI: begin
          iprod_r <= iprod_nxt;
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_data_r  <= sample_nxt;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'(out_data_r);

  `IWO_ASSERT_IMPL(a_inc_below_limit, state_r == S_PHASE, LIMIT_W'(inc_sat) < limit)
  `IWO_ASSERT_IMPL(a_phase_in_range, state_r == S_RDA, LIMIT_W'(phase_r) < limit)
  `IWO_ASSERT_IMPL(a_result_from_step, $rose(out_valid_r), $past(state_r == S_OUT))
  `IWO_ASSERT_IMPL(a_upper_in_range, state_r == S_RDB, LEN_W'(upper) < len_eff)

endmodule
